// ===== rtl/fadst_pkg.sv =====
`default_nettype none

package fadst_pkg;

    // Default geometry and store widths.
    localparam int LOG_WIDTH_DEF    = 8;
    localparam int LOG_HEIGHT_DEF   = 8;
    localparam int DEPTH_BITS_DEF   = 24;
    localparam int STENCIL_BITS_DEF = 8;

    // Widest values the parameters may take.
    localparam int MAX_LOG          = 12;
    localparam int MAX_DEPTH_BITS   = 32;
    localparam int MAX_STENCIL_BITS = 16;

    // Field widths of the stream payloads.
    localparam int POS_W     = 8;
    localparam int FDEPTH_W  = 24;
    localparam int ALPHA_W   = 8;
    localparam int COLOR_W   = 32;
    localparam int CAUSE_W   = 2;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_CONTROL      = 3'd0,
        REG_ALPHA_FUNC         = 3'd1,
        REG_ALPHA_REF          = 3'd2,
        REG_STENCIL_FUNC       = 3'd3,
        REG_STENCIL_REF        = 3'd4,
        REG_STENCIL_MASK       = 3'd5,
        REG_STENCIL_WRITE_MASK = 3'd6,
        REG_STENCIL_OPS        = 3'd7
    } cfg_index_t;

    // Compare functions shared by the alpha and stencil tests.
    typedef enum logic [2:0] {
        CMP_NEVER    = 3'd0,
        CMP_LESS     = 3'd1,
        CMP_LEQUAL   = 3'd2,
        CMP_GREATER  = 3'd3,
        CMP_NOTEQUAL = 3'd4,
        CMP_EQUAL    = 3'd5,
        CMP_GEQUAL   = 3'd6,
        CMP_ALWAYS   = 3'd7
    } cmp_func_t;

    // Stencil update operations.
    typedef enum logic [2:0] {
        SOP_KEEP    = 3'd0,
        SOP_ZERO    = 3'd1,
        SOP_REPLACE = 3'd2,
        SOP_INCRSAT = 3'd3,
        SOP_DECRSAT = 3'd4,
        SOP_BITNOT  = 3'd5,
        SOP_INCR    = 3'd6,
        SOP_DECR    = 3'd7
    } stencil_op_t;

    // Test outcome codes.
    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_PASS    = 2'd0,
        CAUSE_ALPHA   = 2'd1,
        CAUSE_DEPTH   = 2'd2,
        CAUSE_STENCIL = 2'd3
    } fail_cause_t;

    // Register reset values.
    localparam logic [1:0] DEPTH_CONTROL_RST      = 2'd0;
    localparam logic [2:0] ALPHA_FUNC_RST         = CMP_ALWAYS;
    localparam logic [7:0] ALPHA_REF_RST          = 8'd0;
    localparam logic [2:0] STENCIL_FUNC_RST       = CMP_ALWAYS;
    localparam logic [7:0] STENCIL_REF_RST        = 8'd0;
    localparam logic [7:0] STENCIL_MASK_RST       = 8'hFF;
    localparam logic [7:0] STENCIL_WRITE_MASK_RST = 8'hFF;
    localparam logic [8:0] STENCIL_OPS_RST        = 9'd0;

    // One result waiting in the output queue.
    typedef struct packed {
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic               color_write;
        fail_cause_t        cause;
    } out_item_t;

    // Compare a against b with the selected function.
    function automatic logic cmp_fn(input logic [MAX_STENCIL_BITS-1:0] a,
                                    input logic [MAX_STENCIL_BITS-1:0] b,
                                    input logic [2:0] fn);
        logic r;
        case (cmp_func_t'(fn))
            CMP_NEVER:    r = 1'b0;
            CMP_LESS:     r = (a < b);
            CMP_LEQUAL:   r = (a <= b);
            CMP_GREATER:  r = (a > b);
            CMP_NOTEQUAL: r = (a != b);
            CMP_EQUAL:    r = (a == b);
            CMP_GEQUAL:   r = (a >= b);
            default:      r = 1'b1;
        endcase
        return r;
    endfunction

    // Apply one stencil operation; lim is the increment limit and the wrap value
    // of a decrement, smask the mask of the stored width.
    function automatic logic [MAX_STENCIL_BITS-1:0] stencil_apply(
        input logic [MAX_STENCIL_BITS-1:0] v,
        input logic [2:0]                  op,
        input logic [MAX_STENCIL_BITS-1:0] lim,
        input logic [MAX_STENCIL_BITS-1:0] sref,
        input logic [MAX_STENCIL_BITS-1:0] smask);
        logic [MAX_STENCIL_BITS-1:0] r;
        case (stencil_op_t'(op))
            SOP_KEEP:    r = v;
            SOP_ZERO:    r = '0;
            SOP_REPLACE: r = sref;
            SOP_INCRSAT: r = (v < lim) ? v + 1'b1 : lim;
            SOP_DECRSAT: r = (v != '0) ? v - 1'b1 : '0;
            SOP_BITNOT:  r = ~v & smask;
            SOP_INCR:    r = (v < lim) ? v + 1'b1 : '0;
            default:     r = (v != '0) ? v - 1'b1 : lim;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fragment_alpha_depth_stencil_test_top.sv =====
// Channel   Direction  Payload
// s_        in         tdata: pos_x, pos_y, frag_depth, frag_alpha, frag_color
// m_        out        tdata: out_x, out_y, out_color; tuser: color_write, fail_cause
// cfg_      in         register index and write data, no read-back
//
// One fragment per cycle is accepted while the output queue has room. The
// memories are read in the cycle of acceptance; the next cycle compares,
// writes back and places the result in the output queue.
// After reset a clearing pass writes the far plane and zero stencil into
// every entry; no fragment is taken then.
// A three-entry output queue absorbs stalls on the result side.
`default_nettype none

module fragment_alpha_depth_stencil_test_top #(
    parameter int LOG_WIDTH    = fadst_pkg::LOG_WIDTH_DEF,
    parameter int LOG_HEIGHT   = fadst_pkg::LOG_HEIGHT_DEF,
    parameter int DEPTH_BITS   = fadst_pkg::DEPTH_BITS_DEF,
    parameter int STENCIL_BITS = fadst_pkg::STENCIL_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // pos_x[7:0], pos_y[15:8], frag_depth[39:16], frag_alpha[47:40],
    // frag_color[79:48]
    input  wire logic [fadst_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // out_x[7:0], out_y[15:8], out_color[47:16]
    output logic [fadst_pkg::M_TDATA_W-1:0]      m_tdata,
    // color_write[0], fail_cause[2:1]
    output logic [fadst_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_wr_en,
    input  wire logic [fadst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fadst_pkg::CFG_DAT_W-1:0] cfg_wdata
);

    localparam int AW     = LOG_WIDTH + LOG_HEIGHT;
    localparam int NPIX   = 1 << AW;
    localparam int MSB    = fadst_pkg::MAX_STENCIL_BITS;
    localparam logic [MSB-1:0] SMASK = MSB'((32'd1 << STENCIL_BITS) - 32'd1);
    localparam int QDEPTH = 3;

    // Configuration registers.
    logic [1:0] depth_control_reg;
    logic [2:0] alpha_func_reg;
    logic [7:0] alpha_ref_reg;
    logic [2:0] stencil_func_reg;
    logic [7:0] stencil_ref_reg;
    logic [7:0] stencil_mask_reg;
    logic [7:0] stencil_write_mask_reg;
    logic [8:0] stencil_ops_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_control_reg      <= fadst_pkg::DEPTH_CONTROL_RST;
            alpha_func_reg         <= fadst_pkg::ALPHA_FUNC_RST;
            alpha_ref_reg          <= fadst_pkg::ALPHA_REF_RST;
            stencil_func_reg       <= fadst_pkg::STENCIL_FUNC_RST;
            stencil_ref_reg        <= fadst_pkg::STENCIL_REF_RST;
            stencil_mask_reg       <= fadst_pkg::STENCIL_MASK_RST;
            stencil_write_mask_reg <= fadst_pkg::STENCIL_WRITE_MASK_RST;
            stencil_ops_reg        <= fadst_pkg::STENCIL_OPS_RST;
        end else if (cfg_wr_en) begin
            case (fadst_pkg::cfg_index_t'(cfg_index))
                fadst_pkg::REG_DEPTH_CONTROL:      depth_control_reg <= cfg_wdata[1:0];
                fadst_pkg::REG_ALPHA_FUNC:         alpha_func_reg <= cfg_wdata[2:0];
                fadst_pkg::REG_ALPHA_REF:          alpha_ref_reg <= cfg_wdata[7:0];
                fadst_pkg::REG_STENCIL_FUNC:       stencil_func_reg <= cfg_wdata[2:0];
                fadst_pkg::REG_STENCIL_REF:        stencil_ref_reg <= cfg_wdata[7:0];
                fadst_pkg::REG_STENCIL_MASK:       stencil_mask_reg <= cfg_wdata[7:0];
                fadst_pkg::REG_STENCIL_WRITE_MASK: stencil_write_mask_reg <= cfg_wdata[7:0];
                fadst_pkg::REG_STENCIL_OPS:        stencil_ops_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clearing pass after reset.
    logic [AW:0] clr_cnt_reg;
    logic        clr_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end else if (!clr_done_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == (AW+1)'(NPIX - 1)) begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    // Input field unpacking and address forming.
    logic [fadst_pkg::POS_W-1:0]    in_x;
    logic [fadst_pkg::POS_W-1:0]    in_y;
    logic [fadst_pkg::FDEPTH_W-1:0] in_depth;
    logic [fadst_pkg::ALPHA_W-1:0]  in_alpha;
    logic [fadst_pkg::COLOR_W-1:0]  in_color;
    logic [fadst_pkg::MAX_LOG-1:0]  x_ext;
    logic [fadst_pkg::MAX_LOG-1:0]  y_ext;
    logic [AW-1:0]                  rd_addr;
    logic [DEPTH_BITS-1:0]          in_z;
    logic                           in_alpha_pass;
    logic                           s_accept;

    assign in_x     = s_tdata[7:0];
    assign in_y     = s_tdata[15:8];
    assign in_depth = s_tdata[39:16];
    assign in_alpha = s_tdata[47:40];
    assign in_color = s_tdata[79:48];
    assign x_ext    = fadst_pkg::MAX_LOG'(in_x);
    assign y_ext    = fadst_pkg::MAX_LOG'(in_y);
    assign rd_addr  = {y_ext[LOG_HEIGHT-1:0], x_ext[LOG_WIDTH-1:0]};
    assign in_z     = DEPTH_BITS'(fadst_pkg::MAX_DEPTH_BITS'(in_depth));
    assign in_alpha_pass = fadst_pkg::cmp_fn(MSB'(in_alpha), MSB'(alpha_ref_reg),
                                             alpha_func_reg);
    assign s_accept = s_tvalid && s_tready;

    // Read stage: fragment waits here while the memories return its entry.
    logic                          s1_valid_reg;
    logic [AW-1:0]                 s1_addr_reg;
    logic [DEPTH_BITS-1:0]         s1_z_reg;
    logic                          s1_alpha_pass_reg;
    logic [fadst_pkg::POS_W-1:0]   s1_x_reg;
    logic [fadst_pkg::POS_W-1:0]   s1_y_reg;
    logic [fadst_pkg::COLOR_W-1:0] s1_color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_addr_reg       <= rd_addr;
            s1_z_reg          <= in_z;
            s1_alpha_pass_reg <= in_alpha_pass;
            s1_x_reg          <= in_x;
            s1_y_reg          <= in_y;
            s1_color_reg      <= in_color;
        end
    end

    // Depth and stencil memories, read-first, with a registered read.
    logic [DEPTH_BITS-1:0]   depth_mem [NPIX];
    logic [STENCIL_BITS-1:0] stencil_mem [NPIX];
    logic [DEPTH_BITS-1:0]   depth_rd_reg;
    logic [STENCIL_BITS-1:0] stencil_rd_reg;
    logic                    d_we;
    logic                    s_we;
    logic [AW-1:0]           wr_addr;
    logic [DEPTH_BITS-1:0]   d_wdata;
    logic [STENCIL_BITS-1:0] s_wdata;

    always_ff @(posedge aclk) begin
        if (d_we) begin
            depth_mem[wr_addr] <= d_wdata;
        end
        depth_rd_reg <= depth_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (s_we) begin
            stencil_mem[wr_addr] <= s_wdata;
        end
        stencil_rd_reg <= stencil_mem[rd_addr];
    end

    // Forwarding of the most recent write, which a read-first read at the same edge missed.
    logic                    fw_dvalid_reg;
    logic                    fw_svalid_reg;
    logic [AW-1:0]           fw_addr_reg;
    logic [DEPTH_BITS-1:0]   fw_depth_reg;
    logic [STENCIL_BITS-1:0] fw_stencil_reg;

    // Test and update stage.
    logic [DEPTH_BITS-1:0]   cur_depth;
    logic [STENCIL_BITS-1:0] cur_stencil;
    logic [MSB-1:0]          cmp_mask;
    logic [MSB-1:0]          sref;
    logic [MSB-1:0]          new_stencil;
    logic                    zpass;
    logic                    spass;
    logic [2:0]              sop;
    logic                    upd_depth;
    fadst_pkg::fail_cause_t  cause;
    fadst_pkg::out_item_t    s1_item;

    always_comb begin
        cur_depth   = (fw_dvalid_reg && (fw_addr_reg == s1_addr_reg))
                      ? fw_depth_reg : depth_rd_reg;
        cur_stencil = (fw_svalid_reg && (fw_addr_reg == s1_addr_reg))
                      ? fw_stencil_reg : stencil_rd_reg;
        cmp_mask = MSB'(stencil_mask_reg) & SMASK;
        sref     = MSB'(stencil_ref_reg) & SMASK;
        spass    = fadst_pkg::cmp_fn(MSB'(cur_stencil) & cmp_mask, sref & cmp_mask,
                                     stencil_func_reg);
        zpass    = !depth_control_reg[0] || (s1_z_reg <= cur_depth);
        if (!spass) begin
            sop = stencil_ops_reg[2:0];
        end else if (!zpass) begin
            sop = stencil_ops_reg[5:3];
        end else begin
            sop = stencil_ops_reg[8:6];
        end
        new_stencil = fadst_pkg::stencil_apply(MSB'(cur_stencil), sop, cmp_mask, sref,
                                               SMASK)
                      & MSB'(stencil_write_mask_reg) & SMASK;
        upd_depth = s1_valid_reg && s1_alpha_pass_reg && depth_control_reg[0]
                    && depth_control_reg[1] && zpass;

        if (!s1_alpha_pass_reg) begin
            cause = fadst_pkg::CAUSE_ALPHA;
        end else if (!zpass) begin
            cause = fadst_pkg::CAUSE_DEPTH;
        end else if (!spass) begin
            cause = fadst_pkg::CAUSE_STENCIL;
        end else begin
            cause = fadst_pkg::CAUSE_PASS;
        end
        s1_item.x           = s1_x_reg;
        s1_item.y           = s1_y_reg;
        s1_item.color       = s1_color_reg;
        s1_item.color_write = (cause == fadst_pkg::CAUSE_PASS);
        s1_item.cause       = cause;

        // The clearing pass owns the write ports until it is done.
        if (!clr_done_reg) begin
            d_we    = 1'b1;
            s_we    = 1'b1;
            wr_addr = clr_cnt_reg[AW-1:0];
            d_wdata = '1;
            s_wdata = '0;
        end else begin
            d_we    = upd_depth;
            s_we    = s1_valid_reg && s1_alpha_pass_reg;
            wr_addr = s1_addr_reg;
            d_wdata = s1_z_reg;
            s_wdata = new_stencil[STENCIL_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_dvalid_reg <= 1'b0;
            fw_svalid_reg <= 1'b0;
        end else begin
            fw_dvalid_reg <= clr_done_reg && d_we;
            fw_svalid_reg <= clr_done_reg && s_we;
        end
    end

    always_ff @(posedge aclk) begin
        fw_addr_reg    <= wr_addr;
        fw_depth_reg   <= d_wdata;
        fw_stencil_reg <= s_wdata;
    end

    // Output queue: every fragment leaving the test stage is written here.
    fadst_pkg::out_item_t q_mem [QDEPTH];
    logic [1:0] q_wr_reg;
    logic [1:0] q_rd_reg;
    logic [1:0] q_cnt_reg;
    logic       q_pop;
    logic [2:0] q_load;
    fadst_pkg::out_item_t q_head;

    assign q_pop  = m_tvalid && m_tready;
    assign q_load = 3'(q_cnt_reg) + 3'(s1_valid_reg);

    // Take a new fragment only if the queue can hold it when it arrives.
    assign s_tready = clr_done_reg && (q_load <= 3'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            if (s1_valid_reg) begin
                q_wr_reg <= (q_wr_reg == 2'(QDEPTH - 1)) ? 2'd0 : q_wr_reg + 2'd1;
            end
            if (q_pop) begin
                q_rd_reg <= (q_rd_reg == 2'(QDEPTH - 1)) ? 2'd0 : q_rd_reg + 2'd1;
            end
            q_cnt_reg <= q_cnt_reg + 2'(s1_valid_reg) - 2'(q_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            q_mem[q_wr_reg] <= s1_item;
        end
    end

    assign q_head   = q_mem[q_rd_reg];
    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign m_tdata  = {q_head.color, q_head.y, q_head.x};
    assign m_tuser  = {q_head.cause, q_head.color_write};

endmodule

`default_nettype wire

// ===== rtl/fadst_checker.sv =====
`default_nettype none

module fadst_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [fadst_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [fadst_pkg::M_TUSER_W-1:0] m_tuser
);

    // Reset empties the output and starts the clearing pass.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !s_tready))
        else $error("outputs not idle after reset");

    // Once an accepted fragment has passed the test stage into the output queue, m_tvalid is high.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> ##1 m_tvalid)
        else $error("result missing two cycles after acceptance");

    // The write flag agrees with the outcome code.
    a_flag_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (m_tuser[2:1] == fadst_pkg::CAUSE_PASS)))
        else $error("color_write disagrees with fail_cause");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind fragment_alpha_depth_stencil_test_top fadst_checker u_fadst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
